### rtl/tag_world_pose_compose_top_macros.svh
// assertion macros used by twpc_back
`ifndef TAG_WORLD_POSE_COMPOSE_TOP_MACROS_SVH
`define TAG_WORLD_POSE_COMPOSE_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define TWPC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define TWPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/twpc_pkg.sv
package twpc_pkg;

  localparam int PosW   = 32;
  localparam int AngW   = 16;
  localparam int CsW    = 32;   // sin/cos, 30 fraction bits
  localparam int Steps  = 28;
  localparam int WideW  = 36;   // difference and accumulated sums
  localparam int ProdW  = 68;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [1:0] RegCamX   = 2'd0;
  localparam logic [1:0] RegCamY   = 2'd1;
  localparam logic [1:0] RegCamAng = 2'd2;

  localparam logic signed [CsW-1:0] OneQ30  = 32'sd1073741824;
  localparam logic signed [CsW-1:0] GainQ30 = 32'sd652032874;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [AngW-1:0]        ang_t;
  typedef logic signed [CsW-1:0]  cs_t;

  typedef struct packed {
    pos_t lx; pos_t ly; ang_t la;
    pos_t tx; pos_t ty; ang_t ta;
    pos_t mx; pos_t my; ang_t ma;
    pos_t sx; pos_t sy; ang_t sa;
  } sight_t;

  function automatic logic [31:0] atan_f(input int i);
    logic [31:0] t [Steps];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005};
    return t[i];
  endfunction

  function automatic pos_t sat_f(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(signed'({1'b0, {(PosW-1){1'b1}}}));
    lo = -hi - WideW'(1);
    if (v > hi) return pos_t'(hi);
    if (v < lo) return pos_t'(lo);
    return pos_t'(v);
  endfunction

  // product of a q30 value, rounded half away from zero
  function automatic logic signed [WideW-1:0] rnd_f(input logic signed [ProdW-1:0] p);
    logic [ProdW-1:0] m;
    logic [ProdW-1:0] r;
    m = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    r = (m + (ProdW'(1) << 29)) >> 30;
    return p[ProdW-1] ? -WideW'(r) : WideW'(r);
  endfunction

endpackage

### rtl/tag_world_pose_compose_top.sv
// path from the input transfer to the result ports: through the input queue, then 4 rotate stages
// (each: input register, 28 cordic steps, multiply, round, add and saturate), then the output
// queue and the result register
// throughput: one sighting per cycle while results are taken and the credit allows launch
// the result queue holds 256 entries plus the result register; launch stalls once in-flight and held results reach 256
// reset: queues empty, camera mount registers cleared to zero
module tag_world_pose_compose_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic signed [31:0] lidar_odom_x_i,
  input  logic signed [31:0] lidar_odom_y_i,
  input  logic signed [15:0] lidar_odom_angle_i,
  input  logic signed [31:0] tag_odom_x_i,
  input  logic signed [31:0] tag_odom_y_i,
  input  logic signed [15:0] tag_odom_angle_i,
  input  logic signed [31:0] matched_x_i,
  input  logic signed [31:0] matched_y_i,
  input  logic signed [15:0] matched_angle_i,
  input  logic signed [31:0] seen_x_i,
  input  logic signed [31:0] seen_y_i,
  input  logic signed [15:0] seen_angle_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] tag_world_x_o,
  output logic signed [31:0] tag_world_y_o,
  output logic signed [15:0] tag_world_angle_o,
  output logic signed [31:0] robot_world_x_o,
  output logic signed [31:0] robot_world_y_o,
  output logic signed [15:0] robot_world_angle_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  twpc_pkg::pos_t cam_x_q, cam_y_q;
  twpc_pkg::ang_t cam_a_q;
  twpc_pkg::sight_t in_item, q_item;
  logic avail, deq;
  twpc_pkg::ang_t ga, ra;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0; cam_y_q <= '0; cam_a_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        twpc_pkg::RegCamX:   cam_x_q <= cfg_data_i;
        twpc_pkg::RegCamY:   cam_y_q <= cfg_data_i;
        twpc_pkg::RegCamAng: cam_a_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{lx: lidar_odom_x_i, ly: lidar_odom_y_i, la: lidar_odom_angle_i,
                     tx: tag_odom_x_i, ty: tag_odom_y_i, ta: tag_odom_angle_i,
                     mx: matched_x_i, my: matched_y_i, ma: matched_angle_i,
                     sx: seen_x_i, sy: seen_y_i, sa: seen_angle_i};

  twpc_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i(in_item),
    .deq_i(deq), .avail_o(avail), .item_o(q_item)
  );

  twpc_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .item_i(q_item), .deq_o(deq),
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q), .cam_a_i(cam_a_q),
    .empty, .pop,
    .gx_o(tag_world_x_o), .gy_o(tag_world_y_o), .ga_o(ga),
    .rx_o(robot_world_x_o), .ry_o(robot_world_y_o), .ra_o(ra)
  );

  assign tag_world_angle_o   = ga;
  assign robot_world_angle_o = ra;
endmodule

### rtl/twpc_cordic.sv
// pipelined sin/cos, one stage per step, with a sideband payload
module twpc_cordic #(
  parameter int SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  twpc_pkg::ang_t       ang_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output twpc_pkg::cs_t        cos_o,
  output twpc_pkg::cs_t        sin_o,
  output logic [SideW-1:0]     side_o
);
  localparam int N = twpc_pkg::Steps;
  localparam int XW = 34;

  logic                 v_q  [N+1];
  logic signed [XW-1:0] x_q  [N+1];
  logic signed [XW-1:0] y_q  [N+1];
  logic signed [32:0]   z_q  [N+1];
  logic                 f_q  [N+1];
  logic [SideW-1:0]     s_q  [N+1];
  logic [31:0]          z0;
  logic                 fl;

  always_comb begin
    z0 = {ang_i, {(32-twpc_pkg::AngW){1'b0}}};
    fl = z0[31] ^ z0[30];
    if (fl) z0[31] = ~z0[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= XW'(twpc_pkg::GainQ30);
      y_q[0] <= '0;
      z_q[0] <= {z0[31], z0};
      f_q[0] <= fl;
      s_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - 33'(twpc_pkg::atan_f(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + 33'(twpc_pkg::atan_f(i));
        end
        f_q[i+1] <= f_q[i];
        s_q[i+1] <= s_q[i];
      end
    end
  end

  function automatic twpc_pkg::cs_t clamp_f(input logic signed [XW-1:0] v, input logic f);
    logic signed [XW-1:0] c;
    c = v;
    if (c > XW'(twpc_pkg::OneQ30)) c = XW'(twpc_pkg::OneQ30);
    if (c < -XW'(twpc_pkg::OneQ30)) c = -XW'(twpc_pkg::OneQ30);
    if (f) c = -c;
    return twpc_pkg::cs_t'(c);
  endfunction

  assign vld_o  = v_q[N];
  assign cos_o  = clamp_f(x_q[N], f_q[N]);
  assign sin_o  = clamp_f(y_q[N], f_q[N]);
  assign side_o = s_q[N];
endmodule

### rtl/twpc_rot.sv
// rotate a vector and add to a base: o = sat(b + sgn*Rot(a)*v), with Rot(-a) when inv_i is set
module twpc_rot #(
  parameter int SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  twpc_pkg::ang_t       ang_i,
  input  logic                 inv_i,
  input  logic                 sub_i,
  input  logic signed [twpc_pkg::WideW-1:0] vx_i,
  input  logic signed [twpc_pkg::WideW-1:0] vy_i,
  input  twpc_pkg::pos_t       bx_i,
  input  twpc_pkg::pos_t       by_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output twpc_pkg::pos_t       ox_o,
  output twpc_pkg::pos_t       oy_o,
  output logic [SideW-1:0]     side_o
);
  localparam int W = twpc_pkg::WideW;
  localparam int PW = 2 * twpc_pkg::PosW + 2 * W + 2;
  localparam int CSide = PW + SideW;

  logic             cv;
  twpc_pkg::cs_t    c, s;
  logic [CSide-1:0] cside;
  logic [CSide-1:0] cin;

  assign cin = {sub_i, inv_i, vx_i, vy_i, bx_i, by_i, side_i} ;

  twpc_cordic #(.SideW(CSide)) u_cs (
    .clk_i, .rst_ni, .en_i, .vld_i, .ang_i, .side_i(cin),
    .vld_o(cv), .cos_o(c), .sin_o(s), .side_o(cside)
  );

  logic                    sb, iv;
  logic signed [W-1:0]     vx, vy;
  twpc_pkg::pos_t          bx, by;
  logic [SideW-1:0]        sd;
  twpc_pkg::cs_t           sn;
  assign {sb, iv, vx, vy, bx, by, sd} = cside;
  assign sn = iv ? -s : s;

  logic                        v1_q, v2_q, v3_q;
  logic signed [twpc_pkg::ProdW-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [W-1:0]         rx_q, ry_q;
  logic                        sb1_q, sb2_q;
  twpc_pkg::pos_t              bx1_q, by1_q, bx2_q, by2_q, ox_q, oy_q;
  logic [SideW-1:0]            sd1_q, sd2_q, sd3_q;
  logic signed [W-1:0]         tx, ty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= cv; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_comb begin
    tx = sb2_q ? W'(bx2_q) - rx_q : W'(bx2_q) + rx_q;
    ty = sb2_q ? W'(by2_q) - ry_q : W'(by2_q) + ry_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= twpc_pkg::ProdW'(vx) * twpc_pkg::ProdW'(c);
      pys_q <= twpc_pkg::ProdW'(vy) * twpc_pkg::ProdW'(sn);
      pxs_q <= twpc_pkg::ProdW'(vx) * twpc_pkg::ProdW'(sn);
      pyc_q <= twpc_pkg::ProdW'(vy) * twpc_pkg::ProdW'(c);
      sb1_q <= sb; bx1_q <= bx; by1_q <= by; sd1_q <= sd;
      rx_q  <= twpc_pkg::rnd_f(pxc_q) - twpc_pkg::rnd_f(pys_q);
      ry_q  <= twpc_pkg::rnd_f(pxs_q) + twpc_pkg::rnd_f(pyc_q);
      sb2_q <= sb1_q; bx2_q <= bx1_q; by2_q <= by1_q; sd2_q <= sd1_q;
      ox_q  <= twpc_pkg::sat_f(tx);
      oy_q  <= twpc_pkg::sat_f(ty);
      sd3_q <= sd2_q;
    end
  end

  assign vld_o  = v3_q;
  assign ox_o   = ox_q;
  assign oy_o   = oy_q;
  assign side_o = sd3_q;
endmodule

### rtl/twpc_front.sv
// accepts sightings into a short queue
module twpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  twpc_pkg::sight_t  item_i,
  input  logic              deq_i,
  output logic              avail_o,
  output twpc_pkg::sight_t  item_o
);
  twpc_pkg::sight_t mem_q [twpc_pkg::QDepth];
  logic [twpc_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [twpc_pkg::QPtrW:0]   cnt_q;
  logic wr, rd;

  assign full    = (cnt_q == (twpc_pkg::QPtrW+1)'(twpc_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign wr      = push && !full;
  assign rd      = deq_i && avail_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (twpc_pkg::QPtrW+1)'(wr) - (twpc_pkg::QPtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end
endmodule

### rtl/twpc_back.sv
// four rotate-add stages; robot and tag poses into an output queue
module twpc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  twpc_pkg::sight_t  item_i,
  output logic              deq_o,
  input  twpc_pkg::pos_t    cam_x_i,
  input  twpc_pkg::pos_t    cam_y_i,
  input  twpc_pkg::ang_t    cam_a_i,
  output logic              empty,
  input  logic              pop,
  output twpc_pkg::pos_t    gx_o,
  output twpc_pkg::pos_t    gy_o,
  output twpc_pkg::ang_t    ga_o,
  output twpc_pkg::pos_t    rx_o,
  output twpc_pkg::pos_t    ry_o,
  output twpc_pkg::ang_t    ra_o
);
  `include "tag_world_pose_compose_top_macros.svh"
  localparam int W = twpc_pkg::WideW;
  localparam int PW = twpc_pkg::PosW;
  localparam int AW = twpc_pkg::AngW;
  localparam int Lat = 4 * (twpc_pkg::Steps + 4);
  localparam int OD = 1 << 8;           // output queue covers the whole pipeline
  localparam int OPW = 8;

  // credit: never launch more than the output queue can hold
  logic [OPW:0] cnt_q;
  logic [OPW:0] infl_q;
  logic [OPW:0] mcnt_q;
  logic en, launch, oq_wr, oq_rd, ld;

  assign en     = 1'b1;
  assign launch = avail_i && ((infl_q + cnt_q) < (OPW+1)'(OD));
  assign deq_o  = launch;

  // stage 1: D = L^-1 * T
  localparam int S1 = 3*AW + 4*PW;
  logic v1; twpc_pkg::pos_t dx, dy; logic [S1-1:0] sd1;
  twpc_rot #(.SideW(S1)) u_r1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(launch), .ang_i(item_i.la),
    .inv_i(1'b1), .sub_i(1'b0),
    .vx_i(W'(item_i.tx) - W'(item_i.lx)), .vy_i(W'(item_i.ty) - W'(item_i.ly)),
    .bx_i('0), .by_i('0),
    .side_i({item_i.ta - item_i.la, item_i.ma, item_i.mx, item_i.my,
             item_i.sa, item_i.sx, item_i.sy}),
    .vld_o(v1), .ox_o(dx), .oy_o(dy), .side_o(sd1)
  );
  twpc_pkg::ang_t da1, ma1, sa1;
  twpc_pkg::pos_t mx1, my1, sx1, sy1;
  assign {da1, ma1, mx1, my1, sa1, sx1, sy1} = sd1;

  // stage 2: R = M * D
  localparam int S2 = 2*AW + 2*PW;
  logic v2; twpc_pkg::pos_t rx2, ry2; logic [S2-1:0] sd2;
  twpc_rot #(.SideW(S2)) u_r2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v1), .ang_i(ma1),
    .inv_i(1'b0), .sub_i(1'b0), .vx_i(W'(dx)), .vy_i(W'(dy)),
    .bx_i(mx1), .by_i(my1),
    .side_i({ma1 + da1, sa1, sx1, sy1}),
    .vld_o(v2), .ox_o(rx2), .oy_o(ry2), .side_o(sd2)
  );
  twpc_pkg::ang_t ra2, sa2; twpc_pkg::pos_t sx2, sy2;
  assign {ra2, sa2, sx2, sy2} = sd2;

  // stage 3: P = R * C
  localparam int S3 = 3*AW + 4*PW;
  logic v3; twpc_pkg::pos_t px3, py3; logic [S3-1:0] sd3;
  twpc_rot #(.SideW(S3)) u_r3 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v2), .ang_i(ra2),
    .inv_i(1'b0), .sub_i(1'b0), .vx_i(W'(cam_x_i)), .vy_i(W'(cam_y_i)),
    .bx_i(rx2), .by_i(ry2),
    .side_i({ra2, ra2 + cam_a_i, sa2, sx2, sy2, rx2, ry2}),
    .vld_o(v3), .ox_o(px3), .oy_o(py3), .side_o(sd3)
  );
  twpc_pkg::ang_t ra3, pa3, sa3; twpc_pkg::pos_t sx3, sy3, rx3, ry3;
  assign {ra3, pa3, sa3, sx3, sy3, rx3, ry3} = sd3;

  // stage 4: G = P - Rot(G.angle) * S
  localparam int S4 = 2*AW + 2*PW;
  logic v4; twpc_pkg::pos_t gx4, gy4; logic [S4-1:0] sd4;
  twpc_rot #(.SideW(S4)) u_r4 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v3), .ang_i(pa3 - sa3),
    .inv_i(1'b0), .sub_i(1'b1), .vx_i(W'(sx3)), .vy_i(W'(sy3)),
    .bx_i(px3), .by_i(py3),
    .side_i({pa3 - sa3, ra3, rx3, ry3}),
    .vld_o(v4), .ox_o(gx4), .oy_o(gy4), .side_o(sd4)
  );

  localparam int RW = 2*AW + 4*PW;
  logic [RW-1:0] oq_q [OD];
  logic [OPW-1:0] owp_q, orp_q;
  logic [RW-1:0] out_q;
  logic out_v_q;

  assign oq_wr = v4;
  assign oq_rd = pop && !empty;
  assign empty = !out_v_q;
  // refill the result register when it is free or being taken
  assign ld    = (mcnt_q != '0) && (!out_v_q || oq_rd);
  assign {gx_o, gy_o, ga_o, rx_o, ry_o, ra_o} = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; infl_q <= '0; mcnt_q <= '0; owp_q <= '0; orp_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (oq_wr) owp_q <= owp_q + 1'b1;
      if (ld) orp_q <= orp_q + 1'b1;
      if (ld) out_v_q <= 1'b1;
      else if (oq_rd) out_v_q <= 1'b0;
      mcnt_q <= mcnt_q + (OPW+1)'(oq_wr) - (OPW+1)'(ld);
      cnt_q  <= cnt_q + (OPW+1)'(oq_wr) - (OPW+1)'(oq_rd);
      infl_q <= infl_q + (OPW+1)'(launch) - (OPW+1)'(oq_wr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) oq_q[owp_q] <= {gx4, gy4, sd4[S4-1 -: AW],
                               twpc_pkg::pos_t'(sd4[2*PW-1:PW]),
                               twpc_pkg::pos_t'(sd4[PW-1:0]),
                               sd4[S4-AW-1 -: AW]};
    if (ld) out_q <= oq_q[orp_q];
  end

  `TWPC_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, 1'b1, (cnt_q + infl_q) <= (OPW+1)'(OD))
  `TWPC_ASSERT_IMP(a_pop_needs_data, clk_i, rst_ni, oq_rd, cnt_q != '0)
  `TWPC_ASSERT_NEXT(a_launch_counts, clk_i, rst_ni, launch && !oq_wr,
                    infl_q == $past(infl_q) + 1'b1)
  `TWPC_ASSERT_IMP(a_lat_fits, clk_i, rst_ni, 1'b1, Lat < OD)
endmodule
